// File: rtl/core/edid_pkg.sv
// Shared types, constants and helpers of the EDID base block parser.
package edid_pkg;

  localparam int unsigned ByteW    = 8;
  localparam int unsigned PosW     = 7;
  localparam int unsigned TextLen  = 13;
  localparam int unsigned IdxW     = 4;
  localparam int unsigned OffW     = 5;

  localparam logic [PosW-1:0]  BlockLast = 7'd127;
  localparam logic [PosW-1:0]  HdrLen    = 7'd8;
  localparam logic [PosW-1:0]  VendHiPos = 7'd8;
  localparam logic [PosW-1:0]  VendLoPos = 7'd9;
  localparam logic [PosW-1:0]  ModelLoPos = 7'd10;
  localparam logic [PosW-1:0]  ModelHiPos = 7'd11;
  localparam logic [PosW-1:0]  DescStart = 7'd54;
  localparam logic [PosW-1:0]  DescEnd   = 7'd126;
  localparam logic [OffW-1:0]  DescLast  = 5'd17;
  localparam logic [OffW-1:0]  OffTag    = 5'd3;
  localparam logic [OffW-1:0]  OffText   = 5'd5;
  localparam logic [ByteW-1:0] TagName   = 8'hfc;
  localparam logic [ByteW-1:0] TagSerial = 8'hff;
  localparam logic [ByteW-1:0] NameEnd   = 8'h0a;
  localparam logic [IdxW-1:0]  TextLast  = 4'd12;
  localparam logic [IdxW-1:0]  TextCount = 4'd13;
  localparam logic [6:0]       CharBase  = 7'd64;

  typedef enum logic [1:0] {
    STATUS_OK      = 2'd0,
    STATUS_BAD_SUM = 2'd1,
    STATUS_BAD_HDR = 2'd2
  } status_e;

  typedef struct packed {
    logic [ByteW-1:0] edid_byte;
    logic             block_start;
  } in_req_t;

  typedef struct packed {
    status_e          status;
    logic [6:0]       vendor_char_first;
    logic [6:0]       vendor_char_second;
    logic [6:0]       vendor_char_third;
    logic [15:0]      model_number;
    logic             name_found;
    logic [IdxW-1:0]  char_index;
    logic [ByteW-1:0] name_char;
    logic             serial_found;
    logic [ByteW-1:0] serial_char;
    logic             run_last;
  } out_req_t;

  // Descriptor scan flags.
  typedef struct packed {
    logic prefix;
    logic name;
    logic serial;
  } desc_flags_t;

  // Everything the emitter needs to replay one finished block.
  typedef struct packed {
    status_e                      status;
    logic [6:0]                   vendor_char_first;
    logic [6:0]                   vendor_char_second;
    logic [6:0]                   vendor_char_third;
    logic [15:0]                  model_number;
    logic                         name_found;
    logic                         serial_found;
    logic [TextLen-1:0][ByteW-1:0] name_chars;
    logic [TextLen-1:0][ByteW-1:0] serial_chars;
  } snap_t;

  // Expected header byte: 00 ff ff ff ff ff ff 00.
  function automatic logic [ByteW-1:0] hdr_byte(input logic [2:0] pos);
    logic [ByteW-1:0] val;
    begin
      val = (pos == 3'd0 || pos == 3'd7) ? 8'h00 : 8'hff;
      return val;
    end
  endfunction

endpackage

// File: rtl/core/edid_parse.sv
// Per-byte parse state of the EDID base block and the end-of-block snapshot.
module edid_parse
  import edid_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    accept_i,
  input  in_req_t req_i,
  output logic    at_last_o,
  output logic    done_o,
  output snap_t   snap_o
);

  logic [PosW-1:0]               pos_q, pos_d;
  logic [ByteW-1:0]              sum_q, sum_d;
  logic                          hdr_ok_q, hdr_ok_d;
  logic [15:0]                   vend_q, vend_d;
  logic [15:0]                   model_q, model_d;
  desc_flags_t                   flags_q, flags_d;
  logic [OffW-1:0]               off_q, off_d;
  logic [TextLen-1:0][ByteW-1:0] name_q, name_d;
  logic                          name_term_q, name_term_d;
  logic                          name_seen_q, name_seen_d;
  logic [TextLen-1:0][ByteW-1:0] serial_q, serial_d;
  logic                          serial_seen_q, serial_seen_d;

  logic [PosW-1:0]  pos;
  logic [OffW-1:0]  off;
  logic [IdxW-1:0]  k;
  logic [ByteW-1:0] b;
  logic             clr;
  status_e          status;

  assign b         = req_i.edid_byte;
  assign clr       = req_i.block_start;
  assign at_last_o = (pos_q == BlockLast);

  always_comb begin
    // A block start restarts from the reset state before this byte applies.
    pos           = clr ? '0 : pos_q;
    sum_d         = clr ? '0 : sum_q;
    hdr_ok_d      = clr ? 1'b1 : hdr_ok_q;
    vend_d        = clr ? '0 : vend_q;
    model_d       = clr ? '0 : model_q;
    flags_d       = clr ? '0 : flags_q;
    name_d        = clr ? '0 : name_q;
    name_term_d   = clr ? 1'b0 : name_term_q;
    name_seen_d   = clr ? 1'b0 : name_seen_q;
    serial_d      = clr ? '0 : serial_q;
    serial_seen_d = clr ? 1'b0 : serial_seen_q;
    off_d         = off_q;
    off           = '0;
    k             = '0;

    sum_d = sum_d + b;
    if (pos < HdrLen && b != hdr_byte(pos[2:0])) begin
      hdr_ok_d = 1'b0;
    end
    if (pos == VendHiPos)  vend_d[15:8]  = b;
    if (pos == VendLoPos)  vend_d[7:0]   = b;
    if (pos == ModelLoPos) model_d[7:0]  = b;
    if (pos == ModelHiPos) model_d[15:8] = b;

    if (pos >= DescStart && pos < DescEnd) begin
      off   = (pos == DescStart) ? '0 : off_q;
      off_d = (off == DescLast) ? '0 : off + 5'd1;
      k     = 4'(off - OffText);
      if (off == '0) begin
        flags_d        = '0;
        flags_d.prefix = !serial_seen_d && (b == '0);
      end else if (off == 5'd1 || off == 5'd2) begin
        if (b != '0) flags_d.prefix = 1'b0;
      end else if (off == OffTag) begin
        if (!serial_seen_d && flags_d.prefix) begin
          if (b == TagName) begin
            flags_d.name = 1'b1;
            name_seen_d  = 1'b1;
            name_term_d  = 1'b0;
          end else if (b == TagSerial) begin
            flags_d.serial = 1'b1;
            serial_seen_d  = 1'b1;
          end
        end
      end else if (off >= OffText) begin
        if (flags_d.name) begin
          if (name_term_d) begin
            name_d[k] = '0;
          end else if (b == NameEnd) begin
            name_d[k]   = '0;
            name_term_d = 1'b1;
          end else begin
            name_d[k] = b;
          end
        end else if (flags_d.serial) begin
          serial_d[k] = b;
        end
      end
    end

    if (sum_d != '0) begin
      status = STATUS_BAD_SUM;
    end else if (!hdr_ok_d) begin
      status = STATUS_BAD_HDR;
    end else begin
      status = STATUS_OK;
    end

    snap_o = '0;
    snap_o.status = status;
    if (status == STATUS_OK) begin
      snap_o.vendor_char_first  = CharBase + {2'b00, vend_d[14:10]};
      snap_o.vendor_char_second = CharBase + {2'b00, vend_d[9:8], vend_d[7:5]};
      snap_o.vendor_char_third  = CharBase + {2'b00, vend_d[4:0]};
      snap_o.model_number       = model_d;
      snap_o.name_found         = name_seen_d;
      snap_o.serial_found       = serial_seen_d;
      snap_o.name_chars         = name_d;
      snap_o.serial_chars       = serial_d;
    end

    done_o = accept_i && (pos == BlockLast);
    pos_d  = pos + 7'd1;

    // The last byte closes the block: everything returns to reset.
    if (pos == BlockLast) begin
      pos_d         = '0;
      sum_d         = '0;
      hdr_ok_d      = 1'b1;
      vend_d        = '0;
      model_d       = '0;
      flags_d       = '0;
      name_d        = '0;
      name_term_d   = 1'b0;
      name_seen_d   = 1'b0;
      serial_d      = '0;
      serial_seen_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q         <= '0;
      sum_q         <= '0;
      hdr_ok_q      <= 1'b1;
      vend_q        <= '0;
      model_q       <= '0;
      flags_q       <= '0;
      off_q         <= '0;
      name_q        <= '0;
      name_term_q   <= 1'b0;
      name_seen_q   <= 1'b0;
      serial_q      <= '0;
      serial_seen_q <= 1'b0;
    end else if (accept_i) begin
      pos_q         <= pos_d;
      sum_q         <= sum_d;
      hdr_ok_q      <= hdr_ok_d;
      vend_q        <= vend_d;
      model_q       <= model_d;
      flags_q       <= flags_d;
      off_q         <= off_d;
      name_q        <= name_d;
      name_term_q   <= name_term_d;
      name_seen_q   <= name_seen_d;
      serial_q      <= serial_d;
      serial_seen_q <= serial_seen_d;
    end
  end

endmodule

// File: rtl/core/edid_emit.sv
// Snapshot buffer and result sequencer with the output register.
module edid_emit
  import edid_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     load_i,
  input  snap_t    snap_i,
  output logic     busy_o,
  output logic     out_valid_o,
  input  logic     out_ready_i,
  output out_req_t out_req_o
);

  snap_t           buf_q;
  logic [IdxW-1:0] rem_q, rem_d;
  logic [IdxW-1:0] idx_q, idx_d;
  logic            out_valid_q, out_valid_d;
  out_req_t        out_q, out_d;
  logic            adv;

  assign busy_o = (rem_q != '0);
  assign adv    = busy_o && (!out_valid_q || out_ready_i);

  always_comb begin
    rem_d       = rem_q;
    idx_d       = idx_q;
    out_valid_d = out_valid_q;
    out_d       = out_q;
    if (load_i) begin
      rem_d = (snap_i.status == STATUS_OK) ? TextCount : 4'd1;
      idx_d = '0;
    end else if (adv) begin
      rem_d = rem_q - 4'd1;
      idx_d = idx_q + 4'd1;
    end
    if (adv) begin
      out_valid_d              = 1'b1;
      out_d.status             = buf_q.status;
      out_d.vendor_char_first  = buf_q.vendor_char_first;
      out_d.vendor_char_second = buf_q.vendor_char_second;
      out_d.vendor_char_third  = buf_q.vendor_char_third;
      out_d.model_number       = buf_q.model_number;
      out_d.name_found         = buf_q.name_found;
      out_d.char_index         = idx_q;
      out_d.name_char          = buf_q.name_chars[idx_q];
      out_d.serial_found       = buf_q.serial_found;
      out_d.serial_char        = buf_q.serial_chars[idx_q];
      out_d.run_last           = (rem_q == 4'd1);
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rem_q       <= '0;
      idx_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      rem_q       <= rem_d;
      idx_q       <= idx_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      buf_q <= snap_i;
    end
    out_q <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_req_o   = out_q;

  a_load_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load_i |-> (rem_q == '0))
    else $error("snapshot loaded while a run is still pending");

  a_rem_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rem_q <= TextCount)
    else $error("result count out of range");

  a_last_index: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_q.run_last && out_q.status == STATUS_OK) |->
      (out_q.char_index == TextLast))
    else $error("run ended before the last character");

  a_fail_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_q.status != STATUS_OK) |-> out_q.run_last)
    else $error("failure result not marked as last");

endmodule

// File: rtl/core/edid_base_block_parser_unit.sv
// Top level of the EDID base block parser.
//
// Requests enter on the in_* channel, one EDID byte each, with block_start
// marking byte 0 of a block. Every byte updates the parse state in the cycle
// it is accepted, so the input takes one byte per clock while in_ready_o is
// high. After byte 127 the block state is cleared on its own, and the next
// byte counts as byte 0. On byte 127 the finished block is copied into a
// snapshot buffer, from which the first result is registered onto the out_*
// channel; further results follow one per cycle while out_ready_i is high: one
// failure result (bad checksum, else bad header) or thirteen results with the
// name and serial characters, the last carrying run_last.
// A stalled receiver holds the output register; the next block's bytes are
// still taken. Only the byte that arrives at position 127 of a following
// block waits, with in_ready_o low, until the previous run has left the
// snapshot buffer; this holds even when that byte carries block_start. The
// sustained rate is one byte per cycle whenever the receiver keeps up.
// Reset (rst_ni low, asynchronous) empties the output and returns the parse
// state to byte 0 with a cleared checksum and a passing header check.
module edid_base_block_parser_unit
  import edid_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  input  in_req_t  in_req_i,
  output logic     out_valid_o,
  input  logic     out_ready_i,
  output out_req_t out_req_o
);

  logic  accept;
  logic  at_last;
  logic  done;
  logic  busy;
  snap_t snap;

  // Hold off only a block-closing byte while the previous run is pending.
  assign in_ready_o = !(busy && at_last);
  assign accept     = in_valid_i && in_ready_o;

  edid_parse u_parse (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .accept_i  (accept),
    .req_i     (in_req_i),
    .at_last_o (at_last),
    .done_o    (done),
    .snap_o    (snap)
  );

  edid_emit u_emit (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (done),
    .snap_i      (snap),
    .busy_o      (busy),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_req_o   (out_req_o)
  );

endmodule

// File: tb/tb_top.sv
`timescale 1ns / 1ps
// Self-checking testbench of the EDID base block parser unit.
module tb_top;
  import edid_pkg::*;

  // The receiver's single long hold-off, in clock cycles.
  localparam int unsigned HoldCycles  = 400;
  // Cycles allowed after the last expected result before the verdict.
  localparam int unsigned DrainCycles = 30;
  localparam int unsigned BlockLen    = 128;
  localparam int unsigned DescLen     = 18;
  localparam int unsigned NumDesc     = 4;
  localparam logic [7:0]  HdrEdge     = 8'h00;
  localparam logic [7:0]  HdrFill     = 8'hff;

  // How one 18-byte descriptor slot of a generated block is filled.
  typedef enum int {
    DSC_TIMING,
    DSC_NAME,
    DSC_SERIAL,
    DSC_OTHER_TAG,
    DSC_BAD_PREFIX
  } dsc_kind_e;

  // Tracks the parse of the byte stream and holds the results that each
  // finished block must produce, then compares the block's output with them.
  class block_result_checker;
    logic [PosW-1:0] pos;
    logic [7:0]      sum;
    logic            hdr_ok;
    logic [7:0]      vend_hi, vend_lo, model_lo, model_hi;
    logic            in_prefix, in_name, in_serial;
    logic [7:0]      name_txt [TextLen];
    logic [7:0]      serial_txt [TextLen];
    logic            name_done, name_hit, serial_hit;
    out_req_t        pending_chars [$];
    int unsigned     errors, checked, ok_runs, sum_fails, hdr_fails;
    int unsigned     name_runs, serial_runs;

    function new();
      errors = 0;
      checked = 0;
      ok_runs = 0;
      sum_fails = 0;
      hdr_fails = 0;
      name_runs = 0;
      serial_runs = 0;
      restart();
    endfunction

    // Per-block state as it stands before byte 0.
    function void restart();
      int i;
      pos = '0;
      sum = '0;
      hdr_ok = 1'b1;
      vend_hi = '0;
      vend_lo = '0;
      model_lo = '0;
      model_hi = '0;
      in_prefix = 1'b0;
      in_name = 1'b0;
      in_serial = 1'b0;
      for (i = 0; i < TextLen; i++) begin
        name_txt[i] = '0;
        serial_txt[i] = '0;
      end
      name_done = 1'b0;
      name_hit = 1'b0;
      serial_hit = 1'b0;
    endfunction

    function int unsigned pending_count();
      return pending_chars.size();
    endfunction

    // Updates the parse with one accepted byte; on the last byte of a block
    // it queues the results of the block.
    function void take_byte(in_req_t r);
      logic [7:0] b;
      logic [7:0] hdr_want;
      int off;
      int k;
      b = r.edid_byte;
      if (r.block_start) restart();
      sum = sum + b;
      if (pos < HdrLen) begin
        hdr_want = (pos == 0 || pos == HdrLen - 1) ? HdrEdge : HdrFill;
        if (b != hdr_want) hdr_ok = 1'b0;
      end
      if (pos == VendHiPos) vend_hi = b;
      if (pos == VendLoPos) vend_lo = b;
      if (pos == ModelLoPos) model_lo = b;
      if (pos == ModelHiPos) model_hi = b;
      if (pos >= DescStart && pos < DescEnd) begin
        off = (int'(pos) - int'(DescStart)) % DescLen;
        if (off == 0) begin
          in_prefix = !serial_hit && b == 8'h00;
          in_name = 1'b0;
          in_serial = 1'b0;
        end else if (off < int'(OffTag)) begin
          if (b != 8'h00) in_prefix = 1'b0;
        end else if (off == int'(OffTag)) begin
          // Nothing is tagged once a serial descriptor has been seen.
          if (!serial_hit && in_prefix) begin
            if (b == TagName) begin
              in_name = 1'b1;
              name_hit = 1'b1;
              name_done = 1'b0;
            end else if (b == TagSerial) begin
              in_serial = 1'b1;
              serial_hit = 1'b1;
            end
          end
        end else if (off >= int'(OffText)) begin
          k = off - int'(OffText);
          if (in_name) begin
            if (name_done) begin
              name_txt[k] = 8'h00;
            end else if (b == NameEnd) begin
              name_txt[k] = 8'h00;
              name_done = 1'b1;
            end else begin
              name_txt[k] = b;
            end
          end else if (in_serial) begin
            serial_txt[k] = b;
          end
        end
      end
      if (pos != BlockLast) begin
        pos = pos + 1'b1;
        return;
      end
      queue_run();
      restart();
    endfunction

    function void queue_run();
      out_req_t res;
      int k;
      res = '0;
      if (sum != 8'h00) res.status = STATUS_BAD_SUM;
      else if (!hdr_ok) res.status = STATUS_BAD_HDR;
      else res.status = STATUS_OK;
      if (res.status != STATUS_OK) begin
        res.run_last = 1'b1;
        pending_chars.push_back(res);
        if (res.status == STATUS_BAD_SUM) sum_fails++;
        else hdr_fails++;
        return;
      end
      ok_runs++;
      if (name_hit) name_runs++;
      if (serial_hit) serial_runs++;
      for (k = 0; k < TextLen; k++) begin
        res.vendor_char_first  = {2'b00, vend_hi[6:2]} + CharBase;
        res.vendor_char_second = {2'b00, vend_hi[1:0], vend_lo[7:5]} + CharBase;
        res.vendor_char_third  = {2'b00, vend_lo[4:0]} + CharBase;
        res.model_number = {model_hi, model_lo};
        res.name_found = name_hit;
        res.char_index = IdxW'(k);
        res.name_char = name_txt[k];
        res.serial_found = serial_hit;
        res.serial_char = serial_txt[k];
        res.run_last = (k == TextLen - 1);
        pending_chars.push_back(res);
      end
    endfunction

    function void cmp(string fname, logic [15:0] got, logic [15:0] want);
      if (got !== want) begin
        errors++;
        $display("%0t: %s mismatch: expected 0x%0h, actual 0x%0h",
                 $time, fname, want, got);
      end
    endfunction

    function void check_result(out_req_t got);
      out_req_t want;
      if (pending_chars.size() == 0) begin
        errors++;
        $display("%0t: result with none expected: expected nothing, actual 0x%0h",
                 $time, got);
        return;
      end
      want = pending_chars.pop_front();
      checked++;
      cmp("status", got.status, want.status);
      cmp("vendor_char_first", got.vendor_char_first, want.vendor_char_first);
      cmp("vendor_char_second", got.vendor_char_second, want.vendor_char_second);
      cmp("vendor_char_third", got.vendor_char_third, want.vendor_char_third);
      cmp("model_number", got.model_number, want.model_number);
      cmp("name_found", got.name_found, want.name_found);
      cmp("char_index", got.char_index, want.char_index);
      cmp("name_char", got.name_char, want.name_char);
      cmp("serial_found", got.serial_found, want.serial_found);
      cmp("serial_char", got.serial_char, want.serial_char);
      cmp("run_last", got.run_last, want.run_last);
    endfunction
  endclass

  logic     clk_i     = 1'b0;
  logic     rst_ni    = 1'b0;
  logic     in_valid  = 1'b0;
  logic     in_ready;
  in_req_t  in_req    = '0;
  logic     out_valid;
  logic     out_ready = 1'b0;
  out_req_t out_req;

  block_result_checker sb;

  // Percentage of cycles in which each side idles; zero during the
  // stretch with no idling.
  int          idle_pct = 35;
  // Set by the stimulus to ask the receiver for its long hold-off.
  bit          hold_req = 1'b0;
  int unsigned bytes_sent = 0;
  int unsigned blocks_sent = 0;

  // The block being built, its descriptor plan, and where names end:
  // a negative cut places the 0x0a terminator at random, 13 leaves it out.
  logic [7:0]  blk [BlockLen];
  dsc_kind_e   kinds [NumDesc];
  int          name_cut = -1;

  edid_base_block_parser_unit dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_req_i    (in_req),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_req_o   (out_req)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // Both handshakes are observed with the values that held just before the
  // rising edge; every input is driven with nonblocking assignments, so the
  // sampled values never depend on scheduling order within the time step.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid && in_ready) sb.take_byte(in_req);
      if (out_valid && out_ready) sb.check_result(out_req);
    end
  end

  // Offers one request, idling first at random, and returns at the edge
  // where it is taken. Valid stays high until that edge.
  task automatic send_byte(input logic [7:0] b, input logic st);
    in_req_t r;
    r.edid_byte = b;
    r.block_start = st;
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk_i);
    end
    in_valid <= 1'b1;
    in_req <= r;
    do @(posedge clk_i); while (!in_ready);
    bytes_sent++;
  endtask

  task automatic fill_descriptor(input int base, input dsc_kind_e k);
    int t;
    int j;
    if (k == DSC_TIMING) return;
    blk[base] = 8'h00;
    blk[base + 1] = 8'h00;
    blk[base + 2] = 8'h00;
    case (k)
      DSC_NAME: begin
        blk[base + 3] = TagName;
        blk[base + 4] = 8'h00;
        t = (name_cut < 0) ? $urandom_range(0, TextLen) : name_cut;
        for (j = 0; j < TextLen; j++) begin
          if (j < t) blk[base + 5 + j] = 8'($urandom_range(32, 126));
          else if (j == t) blk[base + 5 + j] = NameEnd;
        end
      end
      DSC_SERIAL: begin
        blk[base + 3] = TagSerial;
      end
      DSC_OTHER_TAG: begin
        case ($urandom_range(0, 4))
          0: blk[base + 3] = 8'hfa;
          1: blk[base + 3] = 8'hfb;
          2: blk[base + 3] = 8'hfd;
          3: blk[base + 3] = 8'hfe;
          default: blk[base + 3] = 8'($urandom);
        endcase
      end
      default: begin
        // A name or serial tag behind a prefix that is not all zero.
        blk[base + $urandom_range(0, 2)] = 8'($urandom_range(1, 255));
        blk[base + 3] = $urandom_range(0, 1) ? TagName : TagSerial;
      end
    endcase
  endtask

  task automatic build_block(input bit bad_hdr);
    int i;
    for (i = 0; i < BlockLen; i++) blk[i] = 8'($urandom);
    for (i = 0; i < HdrLen; i++) blk[i] = (i == 0 || i == HdrLen - 1) ? HdrEdge : HdrFill;
    if (bad_hdr) begin
      i = $urandom_range(0, HdrLen - 1);
      blk[i] = blk[i] ^ 8'($urandom_range(1, 255));
    end
    for (i = 0; i < NumDesc; i++) fill_descriptor(DescStart + i * DescLen, kinds[i]);
  endtask

  task automatic set_ids(input logic [15:0] vendor, input logic [15:0] model);
    blk[VendHiPos] = vendor[15:8];
    blk[VendLoPos] = vendor[7:0];
    blk[ModelLoPos] = model[7:0];
    blk[ModelHiPos] = model[15:8];
  endtask

  // Writes the checksum byte, spoiling it on request.
  task automatic seal_block(input bit bad_sum);
    logic [7:0] s;
    int i;
    s = 8'h00;
    for (i = 0; i < BlockLen - 1; i++) s = s + blk[i];
    blk[BlockLen - 1] = 8'h00 - s;
    if (bad_sum) blk[BlockLen - 1] = blk[BlockLen - 1] + 8'($urandom_range(1, 255));
  endtask

  task automatic send_block(input logic st, input int count);
    int i;
    for (i = 0; i < count; i++) send_byte(blk[i], (i == 0) ? st : 1'b0);
    if (count == BlockLen) blocks_sent++;
  endtask

  function automatic dsc_kind_e pick_kind();
    case ($urandom_range(0, 9))
      0, 1, 2: return DSC_NAME;
      3, 4:    return DSC_SERIAL;
      5:       return DSC_OTHER_TAG;
      6:       return DSC_BAD_PREFIX;
      default: return DSC_TIMING;
    endcase
  endfunction

  task automatic build_random_block();
    int i;
    for (i = 0; i < NumDesc; i++) kinds[i] = pick_kind();
    build_block($urandom_range(0, 5) == 0);
    seal_block($urandom_range(0, 5) == 0);
  endtask

  // Stops offering and waits until every queued result has come out.
  task automatic pause_until_drained();
    in_valid <= 1'b0;
    @(posedge clk_i);
    while (sb.pending_count() != 0) @(posedge clk_i);
  endtask

  // The receiver: random back-pressure, plus one long hold-off on request.
  initial begin : receiver
    int unsigned n;
    wait (rst_ni === 1'b1);
    forever begin
      @(posedge clk_i);
      if (hold_req) begin
        out_ready <= 1'b0;
        for (n = 0; n < HoldCycles; n++) @(posedge clk_i);
        hold_req = 1'b0;
      end else begin
        out_ready <= ($urandom_range(99) >= idle_pct);
      end
    end
  end

  initial begin : stimulus
    int n;
    int len;
    int i;
    bit in_step;
    sb = new();
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Zero vendor and model, a name that ends at its first character,
    // then a serial number.
    name_cut = 0;
    kinds = '{DSC_TIMING, DSC_NAME, DSC_SERIAL, DSC_OTHER_TAG};
    build_block(1'b0);
    set_ids(16'h0000, 16'h0000);
    seal_block(1'b0);
    send_block(1'b1, BlockLen);

    // All-ones vendor and model, two unterminated names where the second
    // wins. It follows the previous block without block_start.
    name_cut = TextLen;
    kinds = '{DSC_NAME, DSC_BAD_PREFIX, DSC_NAME, DSC_TIMING};
    build_block(1'b0);
    set_ids(16'hffff, 16'hffff);
    seal_block(1'b0);
    send_block(1'b0, BlockLen);
    name_cut = -1;

    // A serial descriptor first: nothing after it is examined.
    kinds = '{DSC_SERIAL, DSC_NAME, DSC_SERIAL, DSC_NAME};
    build_block(1'b0);
    seal_block(1'b0);
    send_block(1'b1, BlockLen);

    // Broken header with a correct checksum.
    kinds = '{DSC_NAME, DSC_SERIAL, DSC_TIMING, DSC_TIMING};
    build_block(1'b1);
    seal_block(1'b0);
    send_block(1'b1, BlockLen);

    // Broken header and broken checksum: the checksum is reported.
    build_block(1'b1);
    seal_block(1'b1);
    send_block(1'b1, BlockLen);

    // Broken checksum only.
    build_block(1'b0);
    seal_block(1'b1);
    send_block(1'b0, BlockLen);

    // A block abandoned part way through the descriptors, then restarted.
    kinds = '{DSC_NAME, DSC_NAME, DSC_SERIAL, DSC_NAME};
    build_block(1'b0);
    seal_block(1'b0);
    send_block(1'b1, 70);
    kinds = '{DSC_OTHER_TAG, DSC_BAD_PREFIX, DSC_TIMING, DSC_OTHER_TAG};
    build_block(1'b0);
    seal_block(1'b0);
    send_block(1'b1, BlockLen);

    pause_until_drained();

    // Random blocks, some preceded by noise or by an abandoned block.
    in_step = 1'b1;
    for (n = 0; n < 12; n++) begin
      case ($urandom_range(0, 7))
        0: begin
          len = $urandom_range(1, 20);
          for (i = 0; i < len; i++) send_byte(8'($urandom), $urandom_range(0, 5) == 0);
          in_step = 1'b0;
        end
        1: begin
          build_random_block();
          send_block(1'b1, $urandom_range(1, BlockLen - 1));
          in_step = 1'b0;
        end
        default: ;
      endcase
      build_random_block();
      send_block(in_step ? 1'($urandom_range(0, 1)) : 1'b1, BlockLen);
      in_step = 1'b1;
    end

    // Nobody idles; the receiver holds off long enough for the second
    // block's last byte to be refused while results wait.
    pause_until_drained();
    idle_pct = 0;
    hold_req = 1'b1;
    for (n = 0; n < 3; n++) begin
      build_random_block();
      send_block(1'b1, BlockLen);
    end
    idle_pct = 35;

    for (n = 0; n < 3; n++) begin
      build_random_block();
      send_block(1'b1, BlockLen);
    end

    pause_until_drained();
    repeat (DrainCycles) @(posedge clk_i);

    $display("Run covered %0d bytes in %0d full blocks: %0d good,",
             bytes_sent, blocks_sent, sb.ok_runs);
    $display("%0d bad checksum, %0d bad header, %0d with a name, %0d with a serial.",
             sb.sum_fails, sb.hdr_fails, sb.name_runs, sb.serial_runs);
    $display("%0d results checked, %0d errors.", sb.checked, sb.errors);
    if (sb.errors == 0) begin
      $display("edid_base_block_parser_unit regression: pass");
    end else begin
      $display("edid_base_block_parser_unit regression: fail");
    end
    $finish;
  end

  initial begin : watchdog
    #6_000_000;
    $display("%0t: timeout with %0d results still expected", $time, sb.pending_count());
    $display("edid_base_block_parser_unit regression: fail");
    $finish;
  end

endmodule

// File: edid_base_block_parser_unit.f
rtl/core/edid_pkg.sv
rtl/core/edid_parse.sv
rtl/core/edid_emit.sv
rtl/core/edid_base_block_parser_unit.sv
tb/tb_top.sv
